// ----- design/rcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_pkg
// Types and constants shared by the RC capacitance meter sequencer.
// ----------------------------------------------------------------------------
package rcm_pkg;

  // command codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // status codes reported in the result word
  localparam logic [2:0] STAT_IDLE     = 3'd0;
  localparam logic [2:0] STAT_DIS      = 3'd1;
  localparam logic [2:0] STAT_DIS_PRE  = 3'd2;
  localparam logic [2:0] STAT_MEAS     = 3'd3;
  localparam logic [2:0] STAT_VALID    = 3'd4;
  localparam logic [2:0] STAT_BELOW    = 3'd5;
  localparam logic [2:0] STAT_ABOVE    = 3'd6;
  localparam logic [2:0] STAT_DIS_FAIL = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_LEVEL       = 3'd0;
  localparam logic [2:0] REG_DISCHARGED_LEVEL   = 3'd1;
  localparam logic [2:0] REG_STABLE_TIME_MS     = 3'd2;
  localparam logic [2:0] REG_DISCHARGE_LIMIT_MS = 3'd3;
  localparam logic [2:0] REG_FINE_LIMIT_US      = 3'd4;
  localparam logic [2:0] REG_COARSE_LIMIT_US    = 3'd5;
  localparam logic [2:0] REG_FINE_SCALE         = 3'd6;
  localparam logic [2:0] REG_COARSE_SCALE       = 3'd7;

  // fixed thresholds
  localparam logic [9:0]  CHARGED_LEVEL = 10'd100;
  localparam logic [47:0] MIN_PF        = 48'd100;
  localparam logic [47:0] MAX_PF        = 48'd1000000000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  adc_sample;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } rcm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        was_charged;
    logic [47:0] capacitance_pf;
    logic        fine_active;
    logic        drive_fine;
    logic        drive_coarse;
    logic        drive_discharge;
  } rcm_out_t;

  typedef struct packed {
    logic [9:0]  target_level;
    logic [9:0]  discharged_level;
    logic [15:0] stable_time_ms;
    logic [15:0] discharge_limit_ms;
    logic [31:0] fine_limit_us;
    logic [31:0] coarse_limit_us;
    logic [31:0] fine_scale;
    logic [31:0] coarse_scale;
  } rcm_cfg_t;

endpackage
`default_nettype wire

// ----- design/rc_capacitance_meter_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_capacitance_meter_sequencer_top
// RC time-constant capacitance measurement sequencer: discharge, charge on
// fine or coarse range, compute and classify picofarads.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload    role
//  in        in_valid / in_ready   in_word    start, update or stop command
//  out       out_valid / out_ready out_word   one status word per command
//  cfg       cfg_we                cfg_idx,   register write, no wait
//                                  cfg_data
//
//  Sustains one word per cycle while out_ready stays high. A word passes from
//  the input register through the state update (subtract, one 32x32
//  multiply, compares) into the state registers, then the range
//  classification into the output register.
//  Reset is synchronous; it empties all stages and restores register defaults.
//  Each stage advances when the stage after it is empty or being emptied, so
//  a stalled output holds only as much as fills the pipe.
//
module rc_capacitance_meter_sequencer_top
  import rcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rcm_in_t     in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rcm_out_t         out_word,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);

  rcm_cfg_t cfg;
  rcm_out_t res;

  rcm_in_t  a_word;
  logic     a_valid;
  logic     mid_valid;     // state holds a result not yet moved to output
  logic     out_free;
  logic     mid_free;
  logic     a_go;

  // output register takes a word when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign mid_free = !mid_valid || out_free;
  // apply the held command once the state's last result has moved on
  assign a_go     = a_valid && mid_free;
  assign in_ready = !a_valid || mid_free;

  rcm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  rcm_seq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (a_go),
    .item (a_word),
    .cfg  (cfg),
    .res  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_word <= in_word;
    end
  end

  // mark a pending result when a command updates the state
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_free) begin
      mid_valid <= a_go;
    end
  end

  // output register: snapshot the state before the next command lands
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mid_valid) begin
      out_word <= res;
    end
  end

endmodule
`default_nettype wire

// ----- design/rcm_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module rcm_cfg_regs
  import rcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  output rcm_cfg_t         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level       <= 10'd647;
      cfg.discharged_level   <= 10'd5;
      cfg.stable_time_ms     <= 16'd50;
      cfg.discharge_limit_ms <= 16'd5000;
      cfg.fine_limit_us      <= 32'd1000000;
      cfg.coarse_limit_us    <= 32'd10000000;
      cfg.fine_scale         <= 32'd65536;
      cfg.coarse_scale       <= 32'd65536000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET_LEVEL:       cfg.target_level       <= cfg_data[9:0];
        REG_DISCHARGED_LEVEL:   cfg.discharged_level   <= cfg_data[9:0];
        REG_STABLE_TIME_MS:     cfg.stable_time_ms     <= cfg_data[15:0];
        REG_DISCHARGE_LIMIT_MS: cfg.discharge_limit_ms <= cfg_data[15:0];
        REG_FINE_LIMIT_US:      cfg.fine_limit_us      <= cfg_data;
        REG_COARSE_LIMIT_US:    cfg.coarse_limit_us    <= cfg_data;
        REG_FINE_SCALE:         cfg.fine_scale         <= cfg_data;
        REG_COARSE_SCALE:       cfg.coarse_scale       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/rcm_seq_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_seq_core
// Measurement state, one command applied per enabled cycle; result word is
// formed from the current state.
// ----------------------------------------------------------------------------
module rcm_seq_core
  import rcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     go,
  input  wire rcm_in_t  item,
  input  wire rcm_cfg_t cfg,
  output rcm_out_t      res
);

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_DIS     = 7'b0000010,
    PH_DIS_PRE = 7'b0000100,
    PH_MEAS    = 7'b0001000,
    PH_DONE    = 7'b0010000,  // capacitance taken, class follows from value
    PH_TIMEOUT = 7'b0100000,  // coarse range ran out
    PH_FAIL    = 7'b1000000
  } rcm_phase_t;

  rcm_phase_t  phase, phase_next;
  logic        precharged, precharged_next;
  logic        fine_sel, fine_sel_next;
  logic [31:0] charge_start_us, charge_start_us_next;
  logic [31:0] dis_start_ms, dis_start_ms_next;
  logic [31:0] low_since_ms, low_since_ms_next;
  logic        low_valid, low_valid_next;
  logic [47:0] measured_pf, measured_pf_next;

  logic [31:0] elapsed_us;
  logic [31:0] low_ref_ms;
  logic [31:0] limit_us;
  logic [31:0] scale;
  logic [63:0] product;

  assign elapsed_us = item.now_us - charge_start_us;
  assign low_ref_ms = low_valid ? low_since_ms : item.now_ms;
  assign limit_us   = fine_sel ? cfg.fine_limit_us : cfg.coarse_limit_us;
  assign scale      = fine_sel ? cfg.fine_scale : cfg.coarse_scale;
  assign product    = {32'd0, elapsed_us} * {32'd0, scale};

  always_comb begin
    phase_next           = phase;
    precharged_next      = precharged;
    fine_sel_next        = fine_sel;
    charge_start_us_next = charge_start_us;
    dis_start_ms_next    = dis_start_ms;
    low_since_ms_next    = low_since_ms;
    low_valid_next       = low_valid;
    measured_pf_next     = measured_pf;
    case (item.opcode)
      OP_START: begin
        measured_pf_next  = 48'd0;
        precharged_next   = item.adc_sample > CHARGED_LEVEL;
        fine_sel_next     = 1'b1;
        dis_start_ms_next = item.now_ms;
        low_valid_next    = 1'b0;
        phase_next        = (item.adc_sample > CHARGED_LEVEL) ? PH_DIS_PRE : PH_DIS;
      end
      OP_STOP: begin
        phase_next = PH_IDLE;
      end
      OP_UPDATE: begin
        if (phase == PH_DIS || phase == PH_DIS_PRE) begin
          if (item.adc_sample <= cfg.discharged_level) begin
            low_since_ms_next = low_ref_ms;
            low_valid_next    = 1'b1;
            if ((item.now_ms - low_ref_ms) >= {16'd0, cfg.stable_time_ms}) begin
              phase_next           = PH_MEAS;
              charge_start_us_next = item.now_us;
            end
          end else begin
            low_valid_next = 1'b0;
          end
          // the timeout wins over a charge begun by the same sample
          if ((item.now_ms - dis_start_ms) >= {16'd0, cfg.discharge_limit_ms}) begin
            phase_next = PH_FAIL;
          end
        end else if (phase == PH_MEAS) begin
          if (item.adc_sample >= cfg.target_level) begin
            // product never exceeds 48 bits after the 16.16 shift
            measured_pf_next = product[63:16];
            phase_next       = PH_DONE;
          end else if (elapsed_us >= limit_us) begin
            if (fine_sel) begin
              fine_sel_next     = 1'b0;
              dis_start_ms_next = item.now_ms;
              low_valid_next    = 1'b0;
              phase_next        = PH_DIS;
            end else begin
              phase_next = PH_TIMEOUT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      precharged      <= 1'b0;
      fine_sel        <= 1'b1;
      charge_start_us <= 32'd0;
      dis_start_ms    <= 32'd0;
      low_since_ms    <= 32'd0;
      low_valid       <= 1'b0;
      measured_pf     <= 48'd0;
    end else if (go) begin
      phase           <= phase_next;
      precharged      <= precharged_next;
      fine_sel        <= fine_sel_next;
      charge_start_us <= charge_start_us_next;
      dis_start_ms    <= dis_start_ms_next;
      low_since_ms    <= low_since_ms_next;
      low_valid       <= low_valid_next;
      measured_pf     <= measured_pf_next;
    end
  end

  always_comb begin
    case (phase)
      PH_IDLE:    res.status = STAT_IDLE;
      PH_DIS:     res.status = STAT_DIS;
      PH_DIS_PRE: res.status = STAT_DIS_PRE;
      PH_MEAS:    res.status = STAT_MEAS;
      PH_DONE: begin
        if (measured_pf < MIN_PF) begin
          res.status = STAT_BELOW;
        end else if (measured_pf > MAX_PF) begin
          res.status = STAT_ABOVE;
        end else begin
          res.status = STAT_VALID;
        end
      end
      PH_TIMEOUT: res.status = STAT_ABOVE;
      PH_FAIL:    res.status = STAT_DIS_FAIL;
      default:    res.status = STAT_IDLE;
    endcase
    res.was_charged     = precharged;
    res.capacitance_pf  = measured_pf;
    res.fine_active     = fine_sel;
    res.drive_fine      = (phase == PH_MEAS) && fine_sel;
    res.drive_coarse    = (phase == PH_MEAS) && !fine_sel;
    res.drive_discharge = (phase == PH_DIS) || (phase == PH_DIS_PRE);
  end

endmodule
`default_nettype wire

// ----- design/rcm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks on the sequencer's result words.
// ----------------------------------------------------------------------------
module rcm_checker
  import rcm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire rcm_out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.drive_fine && out_word.drive_coarse) &&
                  !(out_word.drive_discharge &&
                    (out_word.drive_fine || out_word.drive_coarse)))
    else $error("more than one drive active");

  a_dis_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.drive_discharge ==
                  (out_word.status == STAT_DIS || out_word.status == STAT_DIS_PRE))
    else $error("discharge drive disagrees with status");

  a_charge_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.drive_fine || out_word.drive_coarse) ==
                  (out_word.status == STAT_MEAS) &&
                  (!out_word.drive_fine || out_word.fine_active))
    else $error("charge drive disagrees with status or range");

endmodule

bind rc_capacitance_meter_sequencer_top rcm_checker u_rcm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
`default_nettype wire

// ----- dv/rcm_status_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_status_checker
// Watches the command, status and register channels of the capacitance meter
// sequencer. Predicts the status word for every accepted command and compares
// the returned words in order.
// ----------------------------------------------------------------------------
module rcm_status_checker
  import rcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  rcm_in_t     in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rcm_out_t    out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending_words
);

  rcm_cfg_t    regs;
  logic [2:0]  phase;
  logic        precharged;
  logic        fine_sel;
  logic [31:0] charge_start_us;
  logic [31:0] dis_start_ms;
  logic [31:0] low_since_ms;
  logic        low_seen;
  logic [47:0] cap_pf;
  rcm_out_t    status_q[$];

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

  task automatic begin_discharge(input logic [31:0] ms, input logic keep);
    dis_start_ms = ms;
    low_seen     = 1'b0;
    phase        = (keep && precharged) ? STAT_DIS_PRE : STAT_DIS;
  endtask

  task automatic advance_sequencer(input rcm_in_t w, output rcm_out_t s);
    logic [31:0] held_ms;
    logic [31:0] waited_ms;
    logic [31:0] elapsed;
    logic [31:0] scale;
    logic [31:0] limit;
    logic [63:0] product;
    case (w.opcode)
      OP_START: begin
        cap_pf     = '0;
        precharged = (w.adc_sample > CHARGED_LEVEL);
        fine_sel   = 1'b1;
        begin_discharge(w.now_ms, 1'b1);
      end
      OP_STOP: phase = STAT_IDLE;
      OP_UPDATE: begin
        if (phase == STAT_DIS || phase == STAT_DIS_PRE) begin
          if (w.adc_sample <= regs.discharged_level) begin
            if (!low_seen) begin
              low_since_ms = w.now_ms;
              low_seen     = 1'b1;
            end
            held_ms = w.now_ms - low_since_ms;
            if (held_ms >= {16'd0, regs.stable_time_ms}) begin
              phase           = STAT_MEAS;
              charge_start_us = w.now_us;
            end
          end else begin
            low_seen = 1'b0;
          end
          // the discharge timeout wins over a charge started by the same word
          waited_ms = w.now_ms - dis_start_ms;
          if (waited_ms >= {16'd0, regs.discharge_limit_ms}) phase = STAT_DIS_FAIL;
        end else if (phase == STAT_MEAS) begin
          elapsed = w.now_us - charge_start_us;
          scale   = fine_sel ? regs.fine_scale : regs.coarse_scale;
          limit   = fine_sel ? regs.fine_limit_us : regs.coarse_limit_us;
          if (w.adc_sample >= regs.target_level) begin
            // 32x32 product shifted by 16 always fits in 48 bits
            product = {32'd0, elapsed} * {32'd0, scale};
            cap_pf  = product[63:16];
            if (cap_pf < MIN_PF) phase = STAT_BELOW;
            else if (cap_pf > MAX_PF) phase = STAT_ABOVE;
            else phase = STAT_VALID;
          end else if (elapsed >= limit) begin
            if (fine_sel) begin
              fine_sel = 1'b0;
              begin_discharge(w.now_ms, 1'b0);
            end else begin
              phase = STAT_ABOVE;
            end
          end
        end
      end
      default: ;
    endcase
    s.status          = phase;
    s.was_charged     = precharged;
    s.capacitance_pf  = cap_pf;
    s.fine_active     = fine_sel;
    s.drive_fine      = (phase == STAT_MEAS) && fine_sel;
    s.drive_coarse    = (phase == STAT_MEAS) && !fine_sel;
    s.drive_discharge = (phase == STAT_DIS) || (phase == STAT_DIS_PRE);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rcm_out_t want;
    if (rst) begin
      regs.target_level       = 10'd647;
      regs.discharged_level   = 10'd5;
      regs.stable_time_ms     = 16'd50;
      regs.discharge_limit_ms = 16'd5000;
      regs.fine_limit_us      = 32'd1000000;
      regs.coarse_limit_us    = 32'd10000000;
      regs.fine_scale         = 32'd65536;
      regs.coarse_scale       = 32'd65536000;
      phase           = STAT_IDLE;
      precharged      = 1'b0;
      fine_sel        = 1'b1;
      charge_start_us = '0;
      dis_start_ms    = '0;
      low_since_ms    = '0;
      low_seen        = 1'b0;
      cap_pf          = '0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TARGET_LEVEL:       regs.target_level       = cfg_data[9:0];
          REG_DISCHARGED_LEVEL:   regs.discharged_level   = cfg_data[9:0];
          REG_STABLE_TIME_MS:     regs.stable_time_ms     = cfg_data[15:0];
          REG_DISCHARGE_LIMIT_MS: regs.discharge_limit_ms = cfg_data[15:0];
          REG_FINE_LIMIT_US:      regs.fine_limit_us      = cfg_data;
          REG_COARSE_LIMIT_US:    regs.coarse_limit_us    = cfg_data;
          REG_FINE_SCALE:         regs.fine_scale         = cfg_data;
          REG_COARSE_SCALE:       regs.coarse_scale       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_sequencer(in_word, want);
        status_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: status word 0x%0h arrived with none expected", $time, out_word);
        end else begin
          want = status_q.pop_front();
          check_field("status", want.status, out_word.status);
          check_field("was_charged", want.was_charged, out_word.was_charged);
          check_field("capacitance_pf", want.capacitance_pf, out_word.capacitance_pf);
          check_field("fine_active", want.fine_active, out_word.fine_active);
          check_field("drive_fine", want.drive_fine, out_word.drive_fine);
          check_field("drive_coarse", want.drive_coarse, out_word.drive_coarse);
          check_field("drive_discharge", want.drive_discharge, out_word.drive_discharge);
        end
      end
    end
    pending_words = status_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the RC capacitance meter sequencer: a directed walk through
// every measurement outcome on the reset registers, then random measurement
// sequences under several register settings, with random stalls on both
// channels. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
  import rcm_pkg::*;

  // the one command code the package leaves unnamed; the block ignores it
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  rcm_in_t     in_word   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rcm_out_t    out_word;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = REG_TARGET_LEVEL;
  logic [31:0] cfg_data  = '0;
  int          mismatches;
  int          pending_words;

  bit          calm = 1'b0;    // while set, neither side idles
  rcm_cfg_t    setting;        // register values in force for the random part
  logic [31:0] t_us;           // running timestamps for well-formed sequences
  logic [31:0] t_ms;
  int          words_sent = 0;

  always #10 clk = ~clk;

  rc_capacitance_meter_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  rcm_status_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Stall the status channel with a chance of about 22 in a hundred, never while calm.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 22);
  end

  function automatic rcm_in_t make_word(input logic [1:0] op, input logic [9:0] adc,
                                        input logic [31:0] us, input logic [31:0] ms);
    rcm_in_t w;
    w.opcode     = op;
    w.adc_sample = adc;
    w.now_us     = us;
    w.now_ms     = ms;
    return w;
  endfunction

  // Present one command word and hold it until accepted. Called and left at a
  // falling edge; valid stays high so a following word goes out back to back.
  task automatic send_word(input rcm_in_t w);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Advance the running clocks by the given steps and send a command at that time.
  task automatic issue(input logic [1:0] op, input logic [9:0] adc,
                       input logic [31:0] dus, input logic [31:0] dms);
    t_us = t_us + dus;
    t_ms = t_ms + dms;
    send_word(make_word(op, adc, t_us, t_ms));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Drain the block, then rewrite every register. Every command answers,
  // so the pipe is empty once no status word is pending.
  task automatic program_registers(input rcm_cfg_t c);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_TARGET_LEVEL, {22'd0, c.target_level});
    write_reg(REG_DISCHARGED_LEVEL, {22'd0, c.discharged_level});
    write_reg(REG_STABLE_TIME_MS, {16'd0, c.stable_time_ms});
    write_reg(REG_DISCHARGE_LIMIT_MS, {16'd0, c.discharge_limit_ms});
    write_reg(REG_FINE_LIMIT_US, c.fine_limit_us);
    write_reg(REG_COARSE_LIMIT_US, c.coarse_limit_us);
    write_reg(REG_FINE_SCALE, c.fine_scale);
    write_reg(REG_COARSE_SCALE, c.coarse_scale);
    cfg_we  <= 1'b0;
    setting = c;
  endtask

  // Mostly scales that land inside the valid band, sometimes any value.
  function automatic logic [31:0] pick_scale();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0040_0000);
  endfunction

  // Short times and limits so that sequences reach every outcome quickly.
  function automatic rcm_cfg_t brisk_setting();
    rcm_cfg_t c;
    c.target_level       = 10'($urandom_range(200, 1023));
    c.discharged_level   = 10'($urandom_range(0, 60));
    c.stable_time_ms     = 16'($urandom_range(0, 40));
    c.discharge_limit_ms = 16'($urandom_range(60, 600));
    c.fine_limit_us      = $urandom_range(20, 5000);
    c.coarse_limit_us    = $urandom_range(5000, 100000);
    c.fine_scale         = pick_scale();
    c.coarse_scale       = pick_scale();
    return c;
  endfunction

  // One measurement: start, discharge samples, charge samples, with at times a
  // second discharge and charge round for the coarse fallback, now and then a stop.
  // One call in ten sends a single noise word with every field random instead.
  task automatic run_measurement();
    logic [31:0] span;
    logic [9:0]  level;
    if ($urandom_range(0, 9) == 0) begin
      send_word(make_word(2'($urandom_range(0, 3)), 10'($urandom), $urandom, $urandom));
      return;
    end
    issue(OP_START, 10'($urandom_range(0, 1023)), $urandom_range(0, 100),
          $urandom_range(0, 5));
    repeat ($urandom_range(1, 2)) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 4) != 0) level = 10'($urandom_range(0, setting.discharged_level));
        else level = 10'($urandom_range(0, 1023));
        // mostly steps that settle within the stable time, now and then
        // one long enough to run out the discharge limit
        if ($urandom_range(0, 6) != 0) span = setting.stable_time_ms / 2 + 1;
        else span = setting.discharge_limit_ms + 2;
        issue(OP_UPDATE, level, $urandom_range(0, 20), $urandom_range(0, span));
      end
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 2) != 0) level = 10'($urandom_range(0, setting.target_level));
        else level = 10'($urandom_range(setting.target_level, 1023));
        span = ($urandom_range(0, 3) != 0) ? setting.fine_limit_us : setting.coarse_limit_us;
        issue(OP_UPDATE, level, $urandom_range(0, span / 2 + 1), $urandom_range(0, 3));
      end
    end
    if ($urandom_range(0, 3) == 0) issue(OP_STOP, 10'($urandom_range(0, 1023)), 0, 0);
  endtask

  initial begin
    rcm_cfg_t c;
    int       base;
    // start just below the wrap point so the first measurement crosses it
    t_us = 32'hFFFF_FC00;
    t_ms = 32'hFFFF_FFE0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk on the reset registers: target 647, discharged 5,
    // stable 50 ms, discharge limit 5000 ms, fine 1 s, coarse 10 s,
    // 1 pF/us fine and 1000 pF/us coarse.
    send_word(make_word(OP_UPDATE, '0, '0, '0));    // update while idle: no change
    send_word(make_word(OP_RESERVED, '1, '1, '1));  // reserved code: no change
    // precharged part, clean discharge, valid result across the us wrap
    issue(OP_START, 10'd1023, 0, 0);
    issue(OP_UPDATE, 10'd0, 0, 0);
    issue(OP_UPDATE, 10'd3, 0, 20);
    issue(OP_UPDATE, 10'd5, 0, 30);
    issue(OP_UPDATE, 10'd300, 1000, 0);
    issue(OP_UPDATE, 10'd647, 2000, 0);
    issue(OP_STOP, 10'd0, 0, 0);
    // sample at the charged threshold, latch cleared twice, then timeout
    issue(OP_START, 10'd100, 0, 0);
    issue(OP_UPDATE, 10'd6, 0, 10);
    issue(OP_UPDATE, 10'd0, 0, 10);
    issue(OP_UPDATE, 10'd200, 0, 30);
    issue(OP_UPDATE, 10'd0, 0, 4950);
    // fine timeout falls back to coarse, coarse result above range
    issue(OP_START, 10'd0, 0, 0);
    issue(OP_UPDATE, 10'd0, 0, 0);
    issue(OP_UPDATE, 10'd0, 0, 50);
    issue(OP_UPDATE, 10'd646, 1000000, 0);
    issue(OP_UPDATE, 10'd0, 0, 1);
    issue(OP_UPDATE, 10'd0, 0, 50);
    issue(OP_UPDATE, 10'd1023, 2000000, 0);
    // target reached at once: zero picofarads, below range
    issue(OP_START, 10'd50, 0, 0);
    issue(OP_UPDATE, 10'd0, 0, 0);
    issue(OP_UPDATE, 10'd0, 0, 50);
    issue(OP_UPDATE, 10'd700, 0, 0);

    // Random part: six register settings, all-zero and all-ones among them.
    // The fourth runs with no idling on either side.
    base = words_sent;
    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       c = '0;
        2:       c = '1;
        default: c = brisk_setting();
      endcase
      program_registers(c);
      calm = (p == 3);
      t_us = $urandom;
      t_ms = $urandom;
      while (words_sent < base + (p + 1) * 80) run_measurement();
    end

    // Drop valid, wait out the last status words and the pipe.
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest stalled run.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
